// ===== sv/shadow_highlight_palette_lookup_macros.svh =====
// assertion macros for the shadow/highlight palette lookup
// no dependencies; included by the top level
`ifndef SHADOW_HIGHLIGHT_PALETTE_LOOKUP_MACROS_SVH
`define SHADOW_HIGHLIGHT_PALETTE_LOOKUP_MACROS_SVH

// condition implies consequence in the same cycle
`define SHPL_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// condition implies consequence in the next cycle
`define SHPL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== sv/shpl_pkg.sv =====
// package for the shadow/highlight palette lookup: codes and color functions
// no dependencies; used by shpl_cram and shadow_highlight_palette_lookup
package shpl_pkg;

  // item commands
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // shadow/highlight codes from pixel bits 7:6
  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_SHADOW    = 2'd1,
    MODE_HIGHLIGHT = 2'd2,
    MODE_SHADOW_B  = 2'd3
  } mode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegOutputFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] RegShEnable     = 2'd1;

  localparam int unsigned BgrW = 12;
  localparam int unsigned RgbW = 16;

  function automatic logic [BgrW-1:0] bgr_shadow(input logic [BgrW-1:0] c);
    return (c >> 1) & 12'h777;
  endfunction

  function automatic logic [BgrW-1:0] bgr_highlight(input logic [BgrW-1:0] c);
    logic [BgrW:0] t;
    t = {1'b0, c & 12'heee} + 13'h444;
    // saturate a channel whose sum carried out of its nibble
    if (t[4]) t[3:1] = 3'b111;
    if (t[8]) t[7:5] = 3'b111;
    if (t[12]) t[11:9] = 3'b111;
    return t[BgrW-1:0] & 12'heee;
  endfunction

  function automatic logic [RgbW-1:0] to_rgb555(input logic [BgrW-1:0] c);
    return {c[3:0], 1'b0, c[7:4], 2'b00, c[11:8], 1'b0};
  endfunction

  function automatic logic [RgbW-1:0] rgb_shadow(input logic [RgbW-1:0] p);
    return (p >> 1) & 16'h738e;
  endfunction

  function automatic logic [RgbW-1:0] rgb_highlight(input logic [RgbW-1:0] p);
    logic [RgbW:0] t;
    t = {1'b0, p & 16'he71c} + 17'h04208;
    if (t[5]) t[4:2] = 3'b111;
    if (t[11]) t[10:8] = 3'b111;
    if (t[16]) t[15:13] = 3'b111;
    return t[RgbW-1:0] & 16'he71c;
  endfunction

  // final color word from a stored entry, the variant and the format
  function automatic logic [RgbW-1:0] shade(input logic [BgrW-1:0] base,
                                            input mode_e mode,
                                            input logic rgb);
    logic [RgbW-1:0] p;
    logic [RgbW-1:0] res;
    p = to_rgb555(base);
    if (!rgb) begin
      if (mode == MODE_HIGHLIGHT) res = {4'h0, bgr_highlight(base)};
      else if (mode != MODE_NORMAL) res = {4'h0, bgr_shadow(base)};
      else res = {4'h0, base};
    end else begin
      if (mode == MODE_HIGHLIGHT) res = rgb_highlight(p);
      else if (mode != MODE_NORMAL) res = rgb_shadow(p);
      else res = p;
    end
    return res;
  endfunction

endpackage

// ===== sv/shpl_cram.sv =====
// color RAM: synchronous memory with one write and one registered read port
// per-entry valid bits make unwritten entries read as zero; uses shpl_pkg
module shpl_cram #(
  parameter int unsigned Entries = 64,
  parameter int unsigned AddrW   = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [shpl_pkg::BgrW-1:0]  wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [shpl_pkg::BgrW-1:0]  rdata_o
);

  logic [shpl_pkg::BgrW-1:0] mem [Entries];
  logic [Entries-1:0]        vld_q;
  logic [shpl_pkg::BgrW-1:0] rdata_q;
  logic                      rvld_q;

  // memory array write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // valid bits and registered valid of the read entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  // an entry never written reads as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== sv/shadow_highlight_palette_lookup.sv =====
// top level of the shadow/highlight palette lookup
// depends on shpl_pkg, shpl_cram and shadow_highlight_palette_lookup_macros.svh
//
//   channel   ports                                        transfer when
//   --------  -------------------------------------------  ------------------------
//   item      start_i, busy_o, cmd_i, entry_index_i,       start_i && !busy_o
//             entry_color_i, pixel_i
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,       cfg_valid_i && cfg_ready_o
//             cfg_data_i
//   result    color_valid_o, color_o                       color_valid_o
//
// One item is taken every cycle; busy_o stays low.
// A lookup's color passes the color RAM read port and then the shading and
// output register before it shows on color_o.
// A write lands in the color RAM at its transfer edge and gives no result.
// After reset all entries read as zero and both registers are zero.
// The receiver cannot stall, so nothing holds the pipeline.
`include "shadow_highlight_palette_lookup_macros.svh"

module shadow_highlight_palette_lookup #(
  parameter int unsigned COLOR_ENTRIES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               cmd_i,
  input  logic [$clog2(COLOR_ENTRIES)-1:0]   entry_index_i,
  input  logic [shpl_pkg::BgrW-1:0]          entry_color_i,
  input  logic [7:0]                         pixel_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [shpl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic                               cfg_data_i,
  output logic                               color_valid_o,
  output logic [shpl_pkg::RgbW-1:0]          color_o
);

  localparam int unsigned AddrW = $clog2(COLOR_ENTRIES);

  logic                      item_xfer;
  logic                      wr_en;
  logic                      lk_en;
  logic                      fmt_q;
  logic                      she_q;
  logic                      lk_q;
  shpl_pkg::mode_e           mode_d;
  shpl_pkg::mode_e           mode_q;
  logic                      rgb_q;
  logic [shpl_pkg::BgrW-1:0] base;
  logic                      out_vld_q;
  logic [shpl_pkg::RgbW-1:0] color_d;
  logic [shpl_pkg::RgbW-1:0] color_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign item_xfer = start_i && !busy_o;
  assign wr_en     = item_xfer && (cmd_i == shpl_pkg::CMD_WRITE);
  assign lk_en     = item_xfer && (cmd_i == shpl_pkg::CMD_LOOKUP);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
      she_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        shpl_pkg::RegOutputFormat: fmt_q <= cfg_data_i;
        shpl_pkg::RegShEnable:     she_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // color RAM
  shpl_cram #(
    .Entries (COLOR_ENTRIES),
    .AddrW   (AddrW)
  ) u_cram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (entry_index_i),
    .wdata_i (entry_color_i),
    .raddr_i (pixel_i[AddrW-1:0]),
    .rdata_o (base)
  );

  // variant code for the lookup stage
  assign mode_d = she_q ? shpl_pkg::mode_e'(pixel_i[7:6]) : shpl_pkg::MODE_NORMAL;

  // read stage: lookup marker and its side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_q <= 1'b0;
    end else begin
      lk_q <= lk_en;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    rgb_q  <= fmt_q;
  end

  // shading and output register
  assign color_d = shpl_pkg::shade(base, mode_q, rgb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= lk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign color_valid_o = out_vld_q;
  assign color_o       = color_q;

  // a lookup transfer reaches the read stage next cycle
  `SHPL_ASSERT_NEXT(a_lookup_to_read, clk_i, rst_ni, lk_en, lk_q)
  // a write transfer alone never sets the read stage lookup marker
  `SHPL_ASSERT_NEXT(a_write_no_read, clk_i, rst_ni, item_xfer && !lk_en, !lk_q)
  // every result strobe comes from the read stage in the previous cycle
  `SHPL_ASSERT_NOW(a_result_source, clk_i, rst_ni, color_valid_o, $past(lk_q))

endmodule
